>>> sv/bpra_pkg.sv
// ----------------------------------------------------------------------------
// bpra_pkg: shared definitions for the bitmap page run allocator
// Result status codes, register indexes, datapath operation codes and the
// command and status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpra_pkg;

    localparam int POOL_PAGES_DEFAULT = 4096;
    localparam int MAX_RUN            = 64;
    localparam int PAGE_BYTES         = 4096;
    localparam int PAGE_SHIFT         = $clog2(PAGE_BYTES);
    localparam int ROW_BITS           = 8;
    localparam int ROW_SHIFT          = $clog2(ROW_BITS);

    localparam int COUNT_W = 7;
    localparam int PAGES_W = 13;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 2;
    localparam int CFG_IW  = 2;

    localparam logic [PAGES_W-1:0] PAGES_RESET = 13'd3840;
    localparam logic [ADDR_W-1:0]  VBASE_RESET = 32'hC010_0000;
    localparam logic [ADDR_W-1:0]  PBASE_RESET = 32'h0020_0000;

    localparam logic [CFG_IW-1:0] CFG_PAGES_IN_USE = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_VIRTUAL_BASE = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_PHYS_BASE    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_RUN  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_PHYS = 2'd2;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE  = 4'd0;
    localparam t_op OP_CLR   = 4'd1;
    localparam t_op OP_LOAD  = 4'd2;
    localparam t_op OP_VRD0  = 4'd3;
    localparam t_op OP_VSCAN = 4'd4;
    localparam t_op OP_MRD   = 4'd5;
    localparam t_op OP_MWR   = 4'd6;
    localparam t_op OP_PRD   = 4'd7;
    localparam t_op OP_PTAKE = 4'd8;
    localparam t_op OP_PNEXT = 4'd9;
    localparam t_op OP_PFIN  = 4'd10;
    localparam t_op OP_ERRV  = 4'd11;
    localparam t_op OP_ERRP  = 4'd12;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic bad_count;
        logic v_found;
        logic v_end;
        logic m_last;
        logic p_end;
        logic p_hit;
        logic last_page;
        logic out_free;
    } t_flags;

endpackage

`default_nettype wire

>>> sv/bpra_ctrl.sv
// ----------------------------------------------------------------------------
// bpra_ctrl: allocator sequencer
// Steps through the clearing pass, the virtual run search, run marking and
// the physical page assignment, issuing at most one datapath op per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpra_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire bpra_pkg::t_flags i_flags,
    output bpra_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_VRD0  = 4'd2;
    localparam logic [3:0] S_VSCAN = 4'd3;
    localparam logic [3:0] S_VERR  = 4'd4;
    localparam logic [3:0] S_MRD   = 4'd5;
    localparam logic [3:0] S_MWR   = 4'd6;
    localparam logic [3:0] S_PRD   = 4'd7;
    localparam logic [3:0] S_PCHK  = 4'd8;
    localparam logic [3:0] S_PFIN  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = bpra_pkg::OP_NONE;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = bpra_pkg::OP_CLR;
                if (i_flags.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = bpra_pkg::OP_LOAD;
                    n_state  = S_VRD0;
                end
            end
            S_VRD0: begin
                o_cmd.op = bpra_pkg::OP_VRD0;
                n_state  = i_flags.bad_count ? S_VERR : S_VSCAN;
            end
            S_VSCAN: begin
                o_cmd.op = bpra_pkg::OP_VSCAN;
                if (i_flags.v_found) begin
                    n_state = S_MRD;
                end else if (i_flags.v_end) begin
                    n_state = S_VERR;
                end
            end
            S_VERR: begin
                if (i_flags.out_free) begin
                    o_cmd.op = bpra_pkg::OP_ERRV;
                    n_state  = S_IDLE;
                end
            end
            S_MRD: begin
                o_cmd.op = bpra_pkg::OP_MRD;
                n_state  = S_MWR;
            end
            S_MWR: begin
                o_cmd.op = bpra_pkg::OP_MWR;
                n_state  = i_flags.m_last ? S_PRD : S_MRD;
            end
            S_PRD: begin
                o_cmd.op = bpra_pkg::OP_PRD;
                n_state  = S_PCHK;
            end
            S_PCHK: begin
                if (i_flags.p_end) begin
                    if (i_flags.out_free) begin
                        o_cmd.op = bpra_pkg::OP_ERRP;
                        n_state  = S_IDLE;
                    end
                end else if (i_flags.p_hit) begin
                    if (i_flags.out_free) begin
                        o_cmd.op = bpra_pkg::OP_PTAKE;
                        if (i_flags.last_page) begin
                            n_state = S_PFIN;
                        end
                    end
                end else begin
                    o_cmd.op = bpra_pkg::OP_PNEXT;
                    n_state  = S_PRD;
                end
            end
            S_PFIN: begin
                o_cmd.op = bpra_pkg::OP_PFIN;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> sv/bpra_dp.sv
// ----------------------------------------------------------------------------
// bpra_dp: allocator datapath
// Holds both page bitmaps as byte-wide memories, the configuration registers,
// the run search, the marking logic, the physical page picker and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpra_dp #(
    parameter int POOL_PAGES = bpra_pkg::POOL_PAGES_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bpra_pkg::t_cmd                  i_cmd,
    output bpra_pkg::t_flags                     o_flags,
    input  wire logic                            i_cfg_we,
    input  wire logic [bpra_pkg::CFG_IW-1:0]     i_cfg_index,
    input  wire logic [bpra_pkg::ADDR_W-1:0]     i_cfg_data,
    input  wire logic [bpra_pkg::COUNT_W-1:0]    i_page_count,
    input  wire logic                            i_out_stall,
    output logic                                 o_valid,
    output logic [bpra_pkg::STAT_W-1:0]          o_status,
    output logic [bpra_pkg::ADDR_W-1:0]          o_virt_addr,
    output logic [bpra_pkg::ADDR_W-1:0]          o_phys_addr,
    output logic                                 o_last
);

    localparam int RB    = bpra_pkg::ROW_BITS;
    localparam int RS    = bpra_pkg::ROW_SHIFT;
    localparam int CW    = bpra_pkg::COUNT_W;
    localparam int AW    = bpra_pkg::ADDR_W;
    localparam int ROWS  = (POOL_PAGES + RB - 1) / RB;
    localparam int ROW_W = $clog2(ROWS);
    localparam int RC_W  = $clog2(ROWS + 1);
    localparam int IDX_W = $clog2(ROWS * RB + 1);

    localparam logic [IDX_W-1:0] POOL_N = IDX_W'(POOL_PAGES);

    // Configuration registers.
    logic [bpra_pkg::PAGES_W-1:0] r_pages_in_use;
    logic [AW-1:0]                r_vbase;
    logic [AW-1:0]                r_pbase;

    // Working registers.
    logic [CW-1:0]    r_count;
    logic [IDX_W-1:0] r_n;
    logic [CW-1:0]    r_run;
    logic [RC_W-1:0]  r_prow;
    logic [IDX_W-1:0] r_start;
    logic [ROW_W-1:0] r_mrow;
    logic [IDX_W-1:0] r_vidx;
    logic [CW-1:0]    r_left;
    logic [RC_W-1:0]  r_pprow;
    logic [ROW_W-1:0] r_clr;

    // Bitmaps and their registered read data.
    logic [RB-1:0] r_vmap [ROWS];
    logic [RB-1:0] r_pmap [ROWS];
    logic [RB-1:0] r_vq;
    logic [RB-1:0] r_pq;

    // Output register.
    logic                         r_ovalid;
    logic [bpra_pkg::STAT_W-1:0]  r_status;
    logic [AW-1:0]                r_va;
    logic [AW-1:0]                r_pa;
    logic                         r_last;

    bpra_pkg::t_op op;

    logic [IDX_W-1:0] v_base;
    logic [IDX_W-1:0] v_idx [RB];
    logic [CW-1:0]    s_run;
    logic             s_found;
    logic [RS-1:0]    s_fpos;
    logic [IDX_W-1:0] v_start;
    logic [RC_W-1:0]  prow_nxt;

    logic [IDX_W-1:0] m_end;
    logic [IDX_W-1:0] m_last_idx;
    logic [RB-1:0]    m_mask;

    logic [IDX_W-1:0] p_base;
    logic [IDX_W-1:0] p_idx [RB];
    logic             p_hit;
    logic [RS-1:0]    p_pick;

    logic             v_we;
    logic [ROW_W-1:0] v_waddr;
    logic [RB-1:0]    v_wdata;
    logic             v_re;
    logic [ROW_W-1:0] v_raddr;
    logic             p_we;
    logic             emit;
    logic             out_free;
    logic [AW-1:0]    va_now;
    logic [AW-1:0]    pa_now;

    assign op = i_cmd.op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_in_use <= bpra_pkg::PAGES_RESET;
            r_vbase        <= bpra_pkg::VBASE_RESET;
            r_pbase        <= bpra_pkg::PBASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpra_pkg::CFG_PAGES_IN_USE: begin
                    r_pages_in_use <= i_cfg_data[bpra_pkg::PAGES_W-1:0];
                end
                bpra_pkg::CFG_VIRTUAL_BASE: begin
                    r_vbase <= i_cfg_data;
                end
                bpra_pkg::CFG_PHYS_BASE: begin
                    r_pbase <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Run search over one bitmap row, carrying the run length between rows.
    assign v_base   = IDX_W'({r_prow, {RS{1'b0}}});
    assign prow_nxt = r_prow + RC_W'(1);

    always_comb begin
        s_run   = r_run;
        s_found = 1'b0;
        s_fpos  = '0;
        for (int j = 0; j < RB; j++) begin
            v_idx[j] = v_base + IDX_W'(j);
            if (!s_found && (v_idx[j] < r_n)) begin
                if (r_vq[j]) begin
                    s_run = '0;
                end else begin
                    s_run = s_run + CW'(1);
                    if (s_run == r_count) begin
                        s_found = 1'b1;
                        s_fpos  = RS'(j);
                    end
                end
            end
        end
    end

    assign v_start = v_base + IDX_W'(s_fpos) + IDX_W'(1) - IDX_W'(r_count);

    // Marking mask for the current row of the found run.
    assign m_end      = r_start + IDX_W'(r_count);
    assign m_last_idx = m_end - IDX_W'(1);

    always_comb begin
        for (int j = 0; j < RB; j++) begin
            m_mask[j] = (IDX_W'({r_mrow, RS'(j)}) >= r_start)
                        && (IDX_W'({r_mrow, RS'(j)}) < m_end);
        end
    end

    // Lowest free physical page in the held row.
    assign p_base = IDX_W'({r_pprow, {RS{1'b0}}});

    always_comb begin
        p_hit  = 1'b0;
        p_pick = '0;
        for (int j = RB - 1; j >= 0; j--) begin
            p_idx[j] = p_base + IDX_W'(j);
            if (!r_pq[j] && (p_idx[j] < r_n)) begin
                p_hit  = 1'b1;
                p_pick = RS'(j);
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        unique case (op)
            bpra_pkg::OP_LOAD: begin
                r_count <= i_page_count;
                r_n     <= (32'(r_pages_in_use) > 32'(POOL_PAGES)) ? POOL_N
                           : IDX_W'(r_pages_in_use);
                r_run   <= '0;
                r_prow  <= '0;
            end
            bpra_pkg::OP_VSCAN: begin
                r_run  <= s_run;
                r_prow <= prow_nxt;
                if (s_found) begin
                    r_start <= v_start;
                    r_mrow  <= ROW_W'(v_start >> RS);
                    r_vidx  <= v_start;
                    r_left  <= r_count;
                    r_pprow <= '0;
                end
            end
            bpra_pkg::OP_MWR: begin
                r_mrow <= r_mrow + ROW_W'(1);
            end
            bpra_pkg::OP_PTAKE: begin
                r_left <= r_left - CW'(1);
                r_vidx <= r_vidx + IDX_W'(1);
            end
            bpra_pkg::OP_PNEXT: begin
                r_pprow <= r_pprow + RC_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (op == bpra_pkg::OP_CLR) begin
            r_clr <= r_clr + ROW_W'(1);
        end
    end

    // Virtual bitmap memory.
    always_comb begin
        v_we    = 1'b0;
        v_waddr = r_mrow;
        v_wdata = r_vq | m_mask;
        v_re    = 1'b0;
        v_raddr = r_mrow;
        unique case (op)
            bpra_pkg::OP_CLR: begin
                v_we    = 1'b1;
                v_waddr = r_clr;
                v_wdata = '0;
            end
            bpra_pkg::OP_MWR: begin
                v_we = 1'b1;
            end
            bpra_pkg::OP_VRD0: begin
                v_re    = 1'b1;
                v_raddr = '0;
            end
            bpra_pkg::OP_VSCAN: begin
                v_re    = 1'b1;
                v_raddr = prow_nxt[ROW_W-1:0];
            end
            bpra_pkg::OP_MRD: begin
                v_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmap[v_waddr] <= v_wdata;
        end
        if (v_re) begin
            r_vq <= r_vmap[v_raddr];
        end
    end

    // Physical bitmap memory; the read data register doubles as the held row.
    assign p_we = (op == bpra_pkg::OP_CLR) || (op == bpra_pkg::OP_PNEXT)
                  || (op == bpra_pkg::OP_PFIN);

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            if (op == bpra_pkg::OP_CLR) begin
                r_pmap[r_clr] <= '0;
            end else begin
                r_pmap[r_pprow[ROW_W-1:0]] <= r_pq;
            end
        end
        if (op == bpra_pkg::OP_PRD) begin
            r_pq <= r_pmap[r_pprow[ROW_W-1:0]];
        end else if (op == bpra_pkg::OP_PTAKE) begin
            r_pq[p_pick] <= 1'b1;
        end
    end

    // Output register.
    assign emit     = (op == bpra_pkg::OP_PTAKE) || (op == bpra_pkg::OP_ERRV)
                      || (op == bpra_pkg::OP_ERRP);
    assign out_free = !r_ovalid || !i_out_stall;
    assign va_now   = r_vbase + (AW'(r_vidx) << bpra_pkg::PAGE_SHIFT);
    assign pa_now   = r_pbase + (AW'(p_base + IDX_W'(p_pick)) << bpra_pkg::PAGE_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (op)
            bpra_pkg::OP_PTAKE: begin
                r_status <= bpra_pkg::ST_OK;
                r_va     <= va_now;
                r_pa     <= pa_now;
                r_last   <= (r_left == CW'(1));
            end
            bpra_pkg::OP_ERRV: begin
                r_status <= bpra_pkg::ST_NO_RUN;
                r_va     <= '0;
                r_pa     <= '0;
                r_last   <= 1'b1;
            end
            bpra_pkg::OP_ERRP: begin
                r_status <= bpra_pkg::ST_NO_PHYS;
                r_va     <= va_now;
                r_pa     <= '0;
                r_last   <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_status;
    assign o_virt_addr = r_va;
    assign o_phys_addr = r_pa;
    assign o_last      = r_last;

    assign o_flags.clr_done  = (r_clr == ROW_W'(ROWS - 1));
    assign o_flags.bad_count = (r_count == '0) || (r_count > CW'(bpra_pkg::MAX_RUN));
    assign o_flags.v_found   = s_found;
    assign o_flags.v_end     = (v_base >= r_n);
    assign o_flags.m_last    = (r_mrow == ROW_W'(m_last_idx >> RS));
    assign o_flags.p_end     = (p_base >= r_n);
    assign o_flags.p_hit     = p_hit;
    assign o_flags.last_page = (r_left == CW'(1));
    assign o_flags.out_free  = out_free;

endmodule

`default_nettype wire

>>> sv/bitmap_page_run_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator: first-fit page run allocator
// Each request item carries a page count. The block claims the lowest run of
// that many free virtual pages, backs each page with the lowest free physical
// page and returns one address pair per page, the last one marked, or an error.
// Input channel: i_valid, o_stall, i_page_count. One request is worked on at
// a time; o_stall is high from acceptance until its final result has been
// loaded into the output register, and in state PFIN after a granted run.
// Output channel: o_valid, i_stall and the result fields. The output register
// holds its item while i_stall is high, and a new request can be accepted
// while the last result of the previous one still waits there.
// Sequence: after acceptance the block scans the virtual bitmap in 8-page rows,
// one per cycle, then reads and rewrites each row that the found run touches,
// then reads the physical rows in turn and takes one page per result, waiting
// whenever the output register is held by i_stall. The bitmap read port, one
// row per access, sets the pace; a full scan of the default 4096-page map
// covers 512 rows.
// Reset: after reset both bitmaps are cleared, one row a cycle over all
// POOL_PAGES/8 rows, rounded up (512 by default), and no item is accepted meanwhile.
// Configuration writes are taken at any time, but belong to idle periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_run_allocator #(
    parameter int POOL_PAGES = bpra_pkg::POOL_PAGES_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bpra_pkg::CFG_IW-1:0]     i_cfg_index,
    input  wire logic [bpra_pkg::ADDR_W-1:0]     i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [bpra_pkg::COUNT_W-1:0]    i_page_count,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [bpra_pkg::STAT_W-1:0]          o_status,
    output logic [bpra_pkg::ADDR_W-1:0]          o_virt_addr,
    output logic [bpra_pkg::ADDR_W-1:0]          o_phys_addr,
    output logic                                 o_last
);

    bpra_pkg::t_cmd   cmd;
    bpra_pkg::t_flags flags;

    bpra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_flags (flags),
        .o_cmd   (cmd)
    );

    bpra_dp #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_flags      (flags),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_page_count (i_page_count),
        .i_out_stall  (i_stall),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_virt_addr  (o_virt_addr),
        .o_phys_addr  (o_phys_addr),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

>>> sv/bpra_checker.sv
// ----------------------------------------------------------------------------
// bpra_checker: port-level checks for the bitmap page run allocator
// Watches the top-level channels and flags results or handshakes that the
// allocator must never produce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpra_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         o_stall,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic [bpra_pkg::STAT_W-1:0]  o_status,
    input wire logic [bpra_pkg::ADDR_W-1:0]  o_virt_addr,
    input wire logic [bpra_pkg::ADDR_W-1:0]  o_phys_addr,
    input wire logic                         o_last
);

    a_reset_clears_output: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_valid
    ) else $error("output item valid straight after reset");

    a_accept_then_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall
    ) else $error("new item taken while a request is in progress");

    a_error_is_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != bpra_pkg::ST_OK)) |-> o_last
    ) else $error("error result not marked as the last of its request");

    a_no_run_zero_addr: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bpra_pkg::ST_NO_RUN))
            |-> ((o_virt_addr == '0) && (o_phys_addr == '0))
    ) else $error("failed run search returned a non-zero address");

    a_stalled_item_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_virt_addr)
            && $stable(o_phys_addr) && $stable(o_last))
    ) else $error("stalled output item changed");

endmodule

bind bitmap_page_run_allocator bpra_checker u_bpra_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the bitmap page run allocator
// Requests are driven in bursts from a queue of page counts. At acceptance a
// first-fit model of both page bitmaps predicts each address pair. A monitor
// checks every result field against the oldest prediction while the receiver
// stalls on a changing pattern. It holds off once for a long stretch. The
// register settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import bpra_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLDOFF_CYCLES = 800;
    localparam int HOLDOFF_AFTER  = 300;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_ITEMS    = 52;
    localparam int MAX_REPORTS    = 60;
    localparam int CYCLE_LIMIT    = 4_000_000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0] phys_addr;
        logic              last;
    } page_result_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_pattern_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index = CFG_PAGES_IN_USE;
    logic [ADDR_W-1:0]   i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic [COUNT_W-1:0]  i_page_count = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [STAT_W-1:0]   o_status;
    logic [ADDR_W-1:0]   o_virt_addr;
    logic [ADDR_W-1:0]   o_phys_addr;
    logic                o_last;

    logic [PAGES_W-1:0]  map_pages = PAGES_RESET;
    logic [ADDR_W-1:0]   virt_base = VBASE_RESET;
    logic [ADDR_W-1:0]   phys_base = PBASE_RESET;
    bit                  virt_used [POOL_PAGES_DEFAULT];
    bit                  phys_used [POOL_PAGES_DEFAULT];

    logic [COUNT_W-1:0]  pending_counts [$];
    page_result_t        expected_pages [$];

    int unsigned         burst_left = 0;
    int unsigned         gap_left = 0;
    int unsigned         delivered = 0;
    int unsigned         mismatches = 0;
    int unsigned         cycle_count = 0;
    int unsigned         holdoff_left = 0;
    int unsigned         pattern_left = 0;
    bit                  holdoff_done = 1'b0;
    stall_pattern_t      stall_pattern = STALL_NONE;

    bitmap_page_run_allocator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_page_count (i_page_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_virt_addr  (o_virt_addr),
        .o_phys_addr  (o_phys_addr),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatches++;
    endtask

    function automatic int unsigned first_free_vpage();
        int unsigned idx;
        idx = 0;
        while (idx < POOL_PAGES_DEFAULT && virt_used[idx]) begin
            idx++;
        end
        return idx;
    endfunction

    // First-fit claim of a virtual run, then lowest-first physical backing.
    task automatic allocate_run(input logic [COUNT_W-1:0] count);
        int unsigned  limit;
        int unsigned  run;
        int unsigned  start;
        int unsigned  idx;
        int unsigned  cursor;
        int unsigned  k;
        bit           found;
        logic [ADDR_W-1:0] va;
        limit = (map_pages > POOL_PAGES_DEFAULT) ? POOL_PAGES_DEFAULT : map_pages;
        found = 1'b0;
        run = 0;
        start = 0;
        idx = 0;
        if (count != 0 && count <= MAX_RUN) begin
            while (!found && idx < limit) begin
                if (virt_used[idx]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == count) begin
                        found = 1'b1;
                        start = idx + 1 - count;
                    end
                end
                idx++;
            end
        end
        if (!found) begin
            expected_pages.push_back(page_result_t'{ST_NO_RUN, 32'd0, 32'd0, 1'b1});
            return;
        end
        for (idx = start; idx < start + count; idx++) begin
            virt_used[idx] = 1'b1;
        end
        cursor = 0;
        for (k = 0; k < count; k++) begin
            va = virt_base + (start + k) * PAGE_BYTES;
            while (cursor < limit && phys_used[cursor]) begin
                cursor++;
            end
            if (cursor >= limit) begin
                expected_pages.push_back(page_result_t'{ST_NO_PHYS, va, 32'd0, 1'b1});
                return;
            end
            phys_used[cursor] = 1'b1;
            expected_pages.push_back(page_result_t'{ST_OK, va,
                phys_base + cursor * PAGE_BYTES, (k + 1 == count)});
            cursor++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] index, input logic [ADDR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_PAGES_IN_USE: begin
                map_pages = value[PAGES_W-1:0];
            end
            CFG_VIRTUAL_BASE: begin
                virt_base = value;
            end
            CFG_PHYS_BASE: begin
                phys_base = value;
            end
            default: begin
            end
        endcase
    endtask

    task automatic wait_until_idle();
        do begin
            @(negedge i_clk);
        end while (pending_counts.size() != 0 || i_valid || expected_pages.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : request_drive
        logic taken;
        taken = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (taken) begin
                allocate_run(i_page_count);
            end
            if (i_valid && !taken) begin
                // The item is held until it is taken.
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_counts.size() != 0) begin
                i_valid <= 1'b1;
                i_page_count <= pending_counts.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : stall_drive
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            i_stall <= 1'b1;
        end else if (!holdoff_done && delivered >= HOLDOFF_AFTER && i_valid) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            i_stall <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                stall_pattern <= stall_pattern_t'($urandom_range(0, 3));
                pattern_left <= $urandom_range(20, 300);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (stall_pattern)
                STALL_NONE: begin
                    i_stall <= 1'b0;
                end
                STALL_LIGHT: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                STALL_HEAVY: begin
                    i_stall <= ($urandom_range(0, 9) < 7);
                end
                default: begin
                    i_stall <= ~i_stall;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        page_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            delivered <= delivered + 1;
            if (expected_pages.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d va %h pa %h",
                    o_status, o_virt_addr, o_phys_addr));
            end else begin
                want = expected_pages.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                        o_status, want.status));
                end
                if (o_virt_addr !== want.virt_addr) begin
                    report_mismatch($sformatf("virt_addr %h, expected %h",
                        o_virt_addr, want.virt_addr));
                end
                if (o_phys_addr !== want.phys_addr) begin
                    report_mismatch($sformatf("phys_addr %h, expected %h",
                        o_phys_addr, want.phys_addr));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last %b, expected %b", o_last, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned lowest_free;
        int unsigned page_limit;
        int unsigned pick;
        int          phase;
        int          item;

        pending_counts = '{7'd1, 7'd64, 7'd0, 7'd65, 7'd127, 7'd2, 7'd3, 7'd64, 7'd1};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_until_idle();

        // An empty map refuses every request.
        write_reg(CFG_PAGES_IN_USE, 32'd0);
        write_reg(CFG_VIRTUAL_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_PHYS_BASE, 32'h8000_0000);
        pending_counts = '{7'd1, 7'd64};
        wait_until_idle();

        // Oversized length is capped, and both address sums wrap.
        write_reg(CFG_PAGES_IN_USE, 32'd8191);
        write_reg(CFG_VIRTUAL_BASE, 32'hFFF8_0000);
        write_reg(CFG_PHYS_BASE, 32'hFFFF_FFFF);
        pending_counts = '{7'd1, 7'd40};
        wait_until_idle();

        // Exactly five free pages remain at the top of the map.
        lowest_free = first_free_vpage();
        write_reg(CFG_PAGES_IN_USE, lowest_free + 5);
        write_reg(CFG_VIRTUAL_BASE, 32'h0000_0000);
        write_reg(CFG_PHYS_BASE, 32'h0000_0000);
        pending_counts = '{7'd6, 7'd5, 7'd1};
        wait_until_idle();

        write_reg(CFG_PAGES_IN_USE, 32'd1);
        pending_counts = '{7'd1};
        wait_until_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            lowest_free = first_free_vpage();
            case ($urandom_range(0, 2))
                0: begin
                    page_limit = POOL_PAGES_DEFAULT;
                end
                1: begin
                    page_limit = $urandom_range(POOL_PAGES_DEFAULT + 1, 8191);
                end
                default: begin
                    page_limit = lowest_free + $urandom_range(0, 300);
                    if (page_limit > POOL_PAGES_DEFAULT) begin
                        page_limit = POOL_PAGES_DEFAULT;
                    end
                end
            endcase
            write_reg(CFG_PAGES_IN_USE, page_limit);
            write_reg(CFG_VIRTUAL_BASE,
                ($urandom_range(0, 3) == 0) ? 32'hFFF0_0000 | $urandom_range(0, 'hFFFFF)
                                            : $urandom);
            write_reg(CFG_PHYS_BASE, $urandom);
            for (item = 0; item < PHASE_ITEMS; item++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    pending_counts.push_back(COUNT_W'($urandom_range(1, 8)));
                end else if (pick < 88) begin
                    pending_counts.push_back(COUNT_W'($urandom_range(9, MAX_RUN)));
                end else if (pick < 93) begin
                    pending_counts.push_back(COUNT_W'(MAX_RUN));
                end else if (pick < 96) begin
                    pending_counts.push_back(7'd0);
                end else begin
                    pending_counts.push_back(COUNT_W'($urandom_range(MAX_RUN + 1, 127)));
                end
            end
            wait_until_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
sv/bpra_pkg.sv
sv/bpra_ctrl.sv
sv/bpra_dp.sv
sv/bitmap_page_run_allocator.sv
sv/bpra_checker.sv
test/tb_top.sv
